// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the deframer RTL.
// Needs clk and rst_n in the including module; NO_ASSERTIONS removes all checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_HOLDS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_HOLDS(lbl, expr)
`define ASSERT_IMPLIES(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/swfd_pkg.sv =====
// Package of the sync word frame deframer: codes, types and the CRC function.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package swfd_pkg;

  localparam logic [15:0] SyncWord = 16'hA596;
  localparam logic [15:0] CrcSeed  = 16'hFFFF;
  localparam logic [15:0] CrcPoly  = 16'h1021;

  localparam logic [7:0] IdImu1     = 8'hA1;
  localparam logic [7:0] IdImu2     = 8'hA2;
  localparam logic [7:0] IdAttitude = 8'hC1;
  localparam logic [7:0] IdRawcount = 8'hF1;
  localparam logic [7:0] IdScaled   = 8'hF2;
  localparam logic [7:0] IdCalib    = 8'hF3;
  localparam logic [7:0] IdValue    = 8'h11;

  localparam int NumRegs    = 7;
  localparam int RegIdxW    = 3;
  localparam int QueueDepth = 2;

  // Slot of an id equals the index of its configuration register.
  localparam logic [RegIdxW-1:0] SlotImu1     = 3'd0;
  localparam logic [RegIdxW-1:0] SlotImu2     = 3'd1;
  localparam logic [RegIdxW-1:0] SlotAttitude = 3'd2;
  localparam logic [RegIdxW-1:0] SlotRawcount = 3'd3;
  localparam logic [RegIdxW-1:0] SlotScaled   = 3'd4;
  localparam logic [RegIdxW-1:0] SlotCalib    = 3'd5;
  localparam logic [RegIdxW-1:0] SlotValue    = 3'd6;
  localparam logic [RegIdxW-1:0] SlotNone     = 3'd7;
  localparam logic [RegIdxW-1:0] RegCount     = 3'd7;

  typedef enum logic [1:0] {
    StatusOk     = 2'd0,
    StatusCrcErr = 2'd1,
    StatusLenErr = 2'd2
  } frame_status_t;

  typedef logic [NumRegs-1:0][7:0] cfg_regs_t;

  localparam cfg_regs_t CfgReset = {8'd1, 8'd1, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0};

  typedef struct packed {
    logic [7:0]         id;
    logic [7:0]         len;
    logic [RegIdxW-1:0] slot;
    logic [15:0]        crc_calc;
    logic [15:0]        crc_rx;
    logic [7:0]         records;
  } frm_evt_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [RegIdxW-1:0] id_slot(input logic [7:0] id);
    logic [RegIdxW-1:0] s;
    case (id)
      IdImu1:     s = SlotImu1;
      IdImu2:     s = SlotImu2;
      IdAttitude: s = SlotAttitude;
      IdRawcount: s = SlotRawcount;
      IdScaled:   s = SlotScaled;
      IdCalib:    s = SlotCalib;
      IdValue:    s = SlotValue;
      default:    s = SlotNone;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/swfd_front.sv =====
// Front end of the deframer: sync hunt, header parse, running CRC and record count.
// Pushes one frame event per finished frame into the queue; uses swfd_pkg.
`timescale 1ns / 1ps
module swfd_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_data_byte,
  input  swfd_pkg::cfg_regs_t  cfg_regs,
  input  swfd_pkg::q_stat_t    q_stat,
  output logic                 q_push,
  output swfd_pkg::frm_evt_t   q_evt
);

  typedef enum logic [2:0] {
    ST_HUNT, ST_ID, ST_LEN, ST_PAYLOAD, ST_CRC_LO, ST_CRC_HI
  } state_t;

  state_t                         state_r, state_nxt;
  logic [15:0]                    sync_r, sync_nxt;
  logic [7:0]                     id_r, id_nxt;
  logic [7:0]                     len_r, len_nxt;
  logic [swfd_pkg::RegIdxW-1:0]   slot_r, slot_nxt;
  logic [15:0]                    crc_r, crc_nxt;
  logic [7:0]                     crc_lo_r, crc_lo_nxt;
  logic [7:0]                     cnt_r, cnt_nxt;
  logic [7:0]                     rec_bytes_r, rec_bytes_nxt;
  logic [7:0]                     records_r, records_nxt;
  logic                           accept;
  logic [15:0]                    crc_upd;
  logic [7:0]                     rec_bytes_inc;
  logic                           is_list;

  assign in_stall      = q_stat.full;
  assign accept        = in_valid && !q_stat.full;
  assign crc_upd       = swfd_pkg::crc16_byte(crc_r, in_data_byte);
  assign rec_bytes_inc = rec_bytes_r + 8'd1;
  assign is_list       = (slot_r >= swfd_pkg::SlotRawcount) && (slot_r != swfd_pkg::SlotNone);

  always_comb begin
    state_nxt     = state_r;
    sync_nxt      = sync_r;
    id_nxt        = id_r;
    len_nxt       = len_r;
    slot_nxt      = slot_r;
    crc_nxt       = crc_r;
    crc_lo_nxt    = crc_lo_r;
    cnt_nxt       = cnt_r;
    rec_bytes_nxt = rec_bytes_r;
    records_nxt   = records_r;
    q_push        = 1'b0;
    q_evt.id       = id_r;
    q_evt.len      = len_r;
    q_evt.slot     = slot_r;
    q_evt.crc_calc = crc_r;
    q_evt.crc_rx   = {in_data_byte, crc_lo_r};
    q_evt.records  = records_r;
    if (accept) begin
      case (state_r)
        ST_HUNT: begin
          sync_nxt = {sync_r[7:0], in_data_byte};
          if (sync_nxt == swfd_pkg::SyncWord) begin
            state_nxt     = ST_ID;
            crc_nxt       = swfd_pkg::CrcSeed;
            rec_bytes_nxt = 8'd0;
            records_nxt   = 8'd0;
          end
        end
        ST_ID: begin
          id_nxt    = in_data_byte;
          slot_nxt  = swfd_pkg::id_slot(in_data_byte);
          crc_nxt   = crc_upd;
          state_nxt = ST_LEN;
        end
        ST_LEN: begin
          len_nxt   = in_data_byte;
          crc_nxt   = crc_upd;
          cnt_nxt   = 8'd0;
          state_nxt = (in_data_byte == 8'd0) ? ST_CRC_LO : ST_PAYLOAD;
        end
        ST_PAYLOAD: begin
          crc_nxt = crc_upd;
          if (is_list) begin
            if (rec_bytes_inc == cfg_regs[slot_r]) begin
              rec_bytes_nxt = 8'd0;
              records_nxt   = records_r + 8'd1;
            end else begin
              rec_bytes_nxt = rec_bytes_inc;
            end
          end
          cnt_nxt = cnt_r + 8'd1;
          if (cnt_nxt == len_r) begin
            state_nxt = ST_CRC_LO;
          end
        end
        ST_CRC_LO: begin
          crc_lo_nxt = in_data_byte;
          state_nxt  = ST_CRC_HI;
        end
        ST_CRC_HI: begin
          q_push    = 1'b1;
          sync_nxt  = 16'd0;
          state_nxt = ST_HUNT;
        end
        default: begin
          state_nxt = ST_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_HUNT;
      sync_r      <= 16'd0;
      id_r        <= 8'd0;
      len_r       <= 8'd0;
      slot_r      <= swfd_pkg::SlotNone;
      crc_r       <= swfd_pkg::CrcSeed;
      crc_lo_r    <= 8'd0;
      cnt_r       <= 8'd0;
      rec_bytes_r <= 8'd0;
      records_r   <= 8'd0;
    end else begin
      state_r     <= state_nxt;
      sync_r      <= sync_nxt;
      id_r        <= id_nxt;
      len_r       <= len_nxt;
      slot_r      <= slot_nxt;
      crc_r       <= crc_nxt;
      crc_lo_r    <= crc_lo_nxt;
      cnt_r       <= cnt_nxt;
      rec_bytes_r <= rec_bytes_nxt;
      records_r   <= records_nxt;
    end
  end

endmodule

// ===== rtl/swfd_fifo.sv =====
// Short queue of finished-frame events between the front and back ends.
// Depth is a parameter; uses swfd_pkg types and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module swfd_fifo #(
  parameter int DEPTH = swfd_pkg::QueueDepth
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  swfd_pkg::frm_evt_t  push_evt,
  input  logic                pop,
  output swfd_pkg::frm_evt_t  head_evt,
  output swfd_pkg::q_stat_t   q_stat
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  swfd_pkg::frm_evt_t  mem_r [DEPTH];
  logic [PtrW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]     count_r, count_nxt;

  assign head_evt     = mem_r[rd_ptr_r];
  assign q_stat.full  = (count_r == FullCnt);
  assign q_stat.empty = (count_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_evt;
    end
  end

  `ASSERT_IMPLIES(a_no_overflow, push, !q_stat.full)
  `ASSERT_IMPLIES(a_no_underflow, pop, !q_stat.empty)
  `ASSERT_HOLDS(a_count_bound, count_r <= FullCnt)

endmodule

// ===== rtl/swfd_back.sv =====
// Back end of the deframer: frame status, per-id totals and the output register.
// Takes events from swfd_fifo; uses swfd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module swfd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  swfd_pkg::cfg_regs_t  cfg_regs,
  input  swfd_pkg::q_stat_t    q_stat,
  input  swfd_pkg::frm_evt_t   q_head,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_message_id,
  output logic [7:0]           out_payload_length,
  output logic [1:0]           out_frame_status,
  output logic [15:0]          out_computed_crc,
  output logic [15:0]          out_received_crc,
  output logic [7:0]           out_record_count,
  output logic [31:0]          out_type_total
);

  logic [31:0]                  totals_r [swfd_pkg::NumRegs];
  logic                         out_valid_r;
  logic [7:0]                   out_id_r;
  logic [7:0]                   out_len_r;
  swfd_pkg::frame_status_t      out_status_r, status_nxt;
  logic [15:0]                  out_crc_calc_r;
  logic [15:0]                  out_crc_rx_r;
  logic [7:0]                   out_count_r, count_nxt;
  logic [31:0]                  out_total_r, total_nxt;
  logic [swfd_pkg::RegIdxW-1:0] slot;
  logic                         is_fixed;
  logic                         is_list;
  logic                         upd;
  logic [31:0]                  tot_cur;
  logic                         res_err;
  logic                         crc_bad;

  assign slot     = q_head.slot;
  assign is_fixed = slot < swfd_pkg::SlotRawcount;
  assign is_list  = (slot >= swfd_pkg::SlotRawcount) && (slot != swfd_pkg::SlotNone);
  assign tot_cur  = (is_fixed || is_list) ? totals_r[slot] : 32'd0;
  assign q_pop    = !q_stat.empty && (!out_valid_r || !out_stall);

  always_comb begin
    status_nxt = swfd_pkg::StatusOk;
    count_nxt  = 8'd0;
    total_nxt  = 32'd0;
    upd        = 1'b0;
    if (q_head.crc_rx != q_head.crc_calc) begin
      status_nxt = swfd_pkg::StatusCrcErr;
    end else if (is_fixed) begin
      if (q_head.len != cfg_regs[slot]) begin
        status_nxt = swfd_pkg::StatusLenErr;
      end else begin
        total_nxt = tot_cur + 32'd1;
        upd       = 1'b1;
      end
    end else if (is_list) begin
      count_nxt = q_head.records;
      total_nxt = tot_cur + {24'd0, q_head.records};
      upd       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int k = 0; k < swfd_pkg::NumRegs; k++) begin
        totals_r[k] <= 32'd0;
      end
    end else begin
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (q_pop && upd) begin
        totals_r[slot] <= total_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_id_r       <= q_head.id;
      out_len_r      <= q_head.len;
      out_status_r   <= status_nxt;
      out_crc_calc_r <= q_head.crc_calc;
      out_crc_rx_r   <= q_head.crc_rx;
      out_count_r    <= count_nxt;
      out_total_r    <= total_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_message_id     = out_id_r;
  assign out_payload_length = out_len_r;
  assign out_frame_status   = out_status_r;
  assign out_computed_crc   = out_crc_calc_r;
  assign out_received_crc   = out_crc_rx_r;
  assign out_record_count   = out_count_r;
  assign out_type_total     = out_total_r;

  assign res_err = out_valid_r && (out_status_r != swfd_pkg::StatusOk);
  assign crc_bad = out_valid_r && (out_crc_rx_r != out_crc_calc_r);

  `ASSERT_IMPLIES(a_err_no_total, res_err, out_total_r == 32'd0 && out_count_r == 8'd0)
  `ASSERT_NEXT(a_pop_loads, q_pop, out_valid_r)
  `ASSERT_IMPLIES(a_crc_status, crc_bad, out_status_r == swfd_pkg::StatusCrcErr)

endmodule

// ===== rtl/sync_word_frame_deframer_crc16.sv =====
// Sync word frame deframer with CRC-16/CCITT-FALSE check and per-id totals.
// Throughput: one byte per cycle; in_stall rises only while the frame-event queue is full.
// Result path: the frame event is queued, then loaded into the output register.
// Reset: synchronous, active low; clears parser, queue, totals and loads register defaults.
`timescale 1ns / 1ps
module sync_word_frame_deframer_crc16 #(
  parameter int QUEUE_DEPTH = swfd_pkg::QueueDepth
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [swfd_pkg::RegIdxW-1:0]  cfg_index,
  input  logic [7:0]                    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_data_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_message_id,
  output logic [7:0]                    out_payload_length,
  output logic [1:0]                    out_frame_status,
  output logic [15:0]                   out_computed_crc,
  output logic [15:0]                   out_received_crc,
  output logic [7:0]                    out_record_count,
  output logic [31:0]                   out_type_total
);

  swfd_pkg::cfg_regs_t  cfg_regs_r;
  swfd_pkg::q_stat_t    q_stat;
  swfd_pkg::frm_evt_t   push_evt;
  swfd_pkg::frm_evt_t   head_evt;
  logic                 q_push;
  logic                 q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_regs_r <= swfd_pkg::CfgReset;
    end else if (cfg_we && (cfg_index < swfd_pkg::RegCount)) begin
      cfg_regs_r[cfg_index] <= cfg_data;
    end
  end

  swfd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .cfg_regs     (cfg_regs_r),
    .q_stat       (q_stat),
    .q_push       (q_push),
    .q_evt        (push_evt)
  );

  swfd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_evt (push_evt),
    .pop      (q_pop),
    .head_evt (head_evt),
    .q_stat   (q_stat)
  );

  swfd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_regs           (cfg_regs_r),
    .q_stat             (q_stat),
    .q_head             (head_evt),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_message_id     (out_message_id),
    .out_payload_length (out_payload_length),
    .out_frame_status   (out_frame_status),
    .out_computed_crc   (out_computed_crc),
    .out_received_crc   (out_received_crc),
    .out_record_count   (out_record_count),
    .out_type_total     (out_type_total)
  );

endmodule
